// ===== hdl/sound_level_light_mode_controller_unit_macros.svh =====
// assertion macros for the sound level light mode controller
// clocked on i_clk; SLMC_ASSERT is quiet while the synchronous reset i_rst_n is low
`ifndef SOUND_LEVEL_LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH
`define SOUND_LEVEL_LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define SLMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked at every clock edge, also while reset is held
`define SLMC_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/slmc_pkg.sv =====
// shared types and constants for the sound level light mode controller
// no dependencies
package slmc_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_POWER_W    = 32;
    localparam int DUTY_W        = 16;
    localparam int BLEND_INDEX_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEEP_THRESHOLD    = 3'd0,
        CFG_DANCE_THRESHOLD    = 3'd1,
        CFG_DANCE_HOLD_FRAMES  = 3'd2,
        CFG_SOS_TICKS          = 3'd3,
        CFG_SLEEP_TICKS        = 3'd4,
        CFG_BLEND_TABLE_LENGTH = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ASLEEP = 2'd0,
        MODE_BLEND  = 2'd1,
        MODE_DANCE  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [31:0] sleep_threshold;
        logic [31:0] dance_threshold;
        logic [15:0] dance_hold_frames;
        logic [15:0] sos_ticks;
        logic [15:0] sleep_ticks;
        logic [15:0] blend_table_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  loud_count;
        logic [15:0] quiet_ticks;
        logic        asleep;
        logic [5:0]  tone_run;
        logic [15:0] hold_timer;
        logic [15:0] dance_ticks;
        logic [15:0] blend_pointer;
    } t_state;

    typedef struct packed {
        t_mode                    mode;
        logic [DUTY_W-1:0]        red_duty;
        logic [DUTY_W-1:0]        green_duty;
        logic [DUTY_W-1:0]        blue_duty;
        logic [BLEND_INDEX_W-1:0] blend_index;
        logic                     tone_alert;
        logic                     sos_alert;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        sleep_threshold:    32'd1000,
        dance_threshold:    32'd100000,
        dance_hold_frames:  16'd200,
        sos_ticks:          16'd7500,
        sleep_ticks:        16'd3750,
        blend_table_length: 16'd1024
    };

    localparam logic [5:0] TONE_RUN_LIMIT = 6'd42;

endpackage

// ===== hdl/slmc_step.sv =====
// next state and result for one request, frame or tick
// depends on slmc_pkg
module slmc_step
    import slmc_pkg::*;
#(
    parameter int BIN_W = 32
) (
    input  t_cfg             i_cfg,
    input  t_state           i_state,
    input  logic             i_func,
    input  logic [BIN_W-1:0] i_bin_one,
    input  logic [BIN_W-1:0] i_bin_two,
    input  logic [BIN_W-1:0] i_bin_three,
    output t_state           o_state,
    output t_result          o_result
);

    localparam logic [IN_POWER_W-3:0] DUTY_CLAMP = (IN_POWER_W-2)'(16'hB000);

    function automatic logic [DUTY_W-1:0] duty_of(input logic [IN_POWER_W-1:0] p);
        logic [IN_POWER_W-3:0] s;
        logic [DUTY_W-1:0]     c;
        s = p[IN_POWER_W-1:2];
        c = (s > DUTY_CLAMP) ? DUTY_CLAMP[DUTY_W-1:0] : s[DUTY_W-1:0];
        return ~c;
    endfunction

    logic [IN_POWER_W-1:0] b0, b1, b2;
    logic [IN_POWER_W-1:0] quarter;
    logic [IN_POWER_W+3:0] b0_x16_ref, b1_x16, b2_x16;
    logic                  loud_any, dominant, all_dance, any_quarter;
    logic [15:0]           bp_inc;
    logic [5:0]            tone_inc;
    t_state                s;
    t_result               r;

    assign b0 = IN_POWER_W'(i_bin_one);
    assign b1 = IN_POWER_W'(i_bin_two);
    assign b2 = IN_POWER_W'(i_bin_three);
    assign quarter = i_cfg.dance_threshold >> 2;

    // shifted compares are done at full width so they cannot wrap
    assign b0_x16_ref = {4'b0000, b0};
    assign b1_x16     = {b1, 4'b0000};
    assign b2_x16     = {b2, 4'b0000};

    assign loud_any = (b0 > i_cfg.sleep_threshold) || (b1 > i_cfg.sleep_threshold)
                   || (b2 > i_cfg.sleep_threshold);
    assign dominant = (b0_x16_ref > b1_x16) && (b0_x16_ref > b2_x16);
    assign all_dance = (b0 > i_cfg.dance_threshold) && (b1 > i_cfg.dance_threshold)
                    && (b2 > i_cfg.dance_threshold);
    assign any_quarter = (b0 > quarter) || (b1 > quarter) || (b2 > quarter);
    assign bp_inc   = i_state.blend_pointer + 16'd1;
    assign tone_inc = i_state.tone_run + 6'd1;

    always_comb begin
        s = i_state;
        r = '{mode: MODE_ASLEEP, default: '0};
        if (i_func) begin
            // timer tick
            if (i_state.loud_count == 8'd0) begin
                s.quiet_ticks = i_state.quiet_ticks + 16'd1;
            end else begin
                s.quiet_ticks = '0;
                s.loud_count  = '0;
            end
            if (s.quiet_ticks > i_cfg.sleep_ticks) begin
                s.asleep = 1'b1;
            end
            s.dance_ticks   = i_state.dance_ticks + 16'd1;
            s.blend_pointer = (bp_inc >= i_cfg.blend_table_length) ? 16'd0 : bp_inc;
            if (s.asleep) begin
                r.mode = MODE_ASLEEP;
            end else if (i_state.hold_timer != 16'd0) begin
                r.mode = MODE_DANCE;
            end else begin
                r.mode = MODE_BLEND;
            end
        end else begin
            // spectral frame
            if (loud_any) begin
                if (i_state.loud_count != 8'hFF) begin
                    s.loud_count = i_state.loud_count + 8'd1;
                end
                s.asleep = 1'b0;
            end
            if (!s.asleep) begin
                if (dominant) begin
                    if (tone_inc == TONE_RUN_LIMIT) begin
                        r.tone_alert = 1'b1;
                        s.tone_run   = '0;
                    end else begin
                        s.tone_run = tone_inc;
                    end
                end else begin
                    s.tone_run = '0;
                end
                if (all_dance || (i_state.hold_timer != 16'd0)) begin
                    if (any_quarter || (i_state.hold_timer == 16'd0)) begin
                        s.hold_timer = i_cfg.dance_hold_frames;
                    end else begin
                        s.hold_timer = i_state.hold_timer - 16'd1;
                    end
                    r.red_duty   = duty_of(b0);
                    r.green_duty = duty_of(b1);
                    r.blue_duty  = duty_of(b2);
                    if (i_state.dance_ticks >= i_cfg.sos_ticks) begin
                        r.sos_alert   = 1'b1;
                        s.dance_ticks = '0;
                    end
                    r.mode = MODE_DANCE;
                end else begin
                    s.hold_timer  = '0;
                    s.dance_ticks = '0;
                    r.mode        = MODE_BLEND;
                end
            end else begin
                s.quiet_ticks = '0;
                s.loud_count  = '0;
            end
        end
        r.blend_index = s.blend_pointer[15:2];
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

// ===== hdl/sound_level_light_mode_controller_unit.sv =====
// top level of the sound level light mode controller: input register, step logic,
// result register and configuration registers; depends on slmc_pkg, slmc_step
// and the assertion macro header
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_func, i_bin_*_power
//  out       output     o_out_valid / i_out_ready   o_mode, o_*_duty, o_blend_index,
//                                                   o_tone_alert, o_sos_alert
//  cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// one request per cycle sustained while results are taken; an accepted request passes
// through the input register, then one pass through the step logic into the result
// register, which also updates the block state
// a stalled result holds the result register; the input register still takes a
// request when it is empty, so both stages fill before o_in_ready drops
// synchronous reset clears the state and loads the register defaults; no clearing pass
`include "sound_level_light_mode_controller_unit_macros.svh"

module sound_level_light_mode_controller_unit
    import slmc_pkg::*;
#(
    parameter int POWER_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_func,
    input  logic [IN_POWER_W-1:0]    i_bin_one_power,
    input  logic [IN_POWER_W-1:0]    i_bin_two_power,
    input  logic [IN_POWER_W-1:0]    i_bin_three_power,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_mode,
    output logic [DUTY_W-1:0]        o_red_duty,
    output logic [DUTY_W-1:0]        o_green_duty,
    output logic [DUTY_W-1:0]        o_blue_duty,
    output logic [BLEND_INDEX_W-1:0] o_blend_index,
    output logic                     o_tone_alert,
    output logic                     o_sos_alert
);

    // only the low bits of each bin power are significant
    localparam int BIN_W = (POWER_BITS < IN_POWER_W) ? POWER_BITS : IN_POWER_W;

    t_cfg             r_cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          r_res;
    t_result          n_res;
    logic             r_in_valid;
    logic             r_func;
    logic [BIN_W-1:0] r_bin_one, r_bin_two, r_bin_three;
    logic             r_out_valid;
    logic             w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLEEP_THRESHOLD:    r_cfg.sleep_threshold    <= i_cfg_data[31:0];
                CFG_DANCE_THRESHOLD:    r_cfg.dance_threshold    <= i_cfg_data[31:0];
                CFG_DANCE_HOLD_FRAMES:  r_cfg.dance_hold_frames  <= i_cfg_data[15:0];
                CFG_SOS_TICKS:          r_cfg.sos_ticks          <= i_cfg_data[15:0];
                CFG_SLEEP_TICKS:        r_cfg.sleep_ticks        <= i_cfg_data[15:0];
                CFG_BLEND_TABLE_LENGTH: r_cfg.blend_table_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func      <= i_func;
            r_bin_one   <= i_bin_one_power[BIN_W-1:0];
            r_bin_two   <= i_bin_two_power[BIN_W-1:0];
            r_bin_three <= i_bin_three_power[BIN_W-1:0];
        end
    end

    slmc_step #(
        .BIN_W (BIN_W)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_func      (r_func),
        .i_bin_one   (r_bin_one),
        .i_bin_two   (r_bin_two),
        .i_bin_three (r_bin_three),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode        = r_res.mode;
    assign o_red_duty    = r_res.red_duty;
    assign o_green_duty  = r_res.green_duty;
    assign o_blue_duty   = r_res.blue_duty;
    assign o_blend_index = r_res.blend_index;
    assign o_tone_alert  = r_res.tone_alert;
    assign o_sos_alert   = r_res.sos_alert;

    // duty values only ever leave in dance mode
    `SLMC_ASSERT(a_duty_only_dance, (o_out_valid && (r_res.mode != MODE_DANCE)) |-> ((o_red_duty == '0) && (o_green_duty == '0) && (o_blue_duty == '0)), "duty output outside dance mode")
    // sos only raised by a dance frame
    `SLMC_ASSERT(a_sos_in_dance, (o_out_valid && o_sos_alert) |-> (r_res.mode == MODE_DANCE), "sos alert outside dance mode")
    // tone alert only while awake
    `SLMC_ASSERT(a_tone_awake, (o_out_valid && o_tone_alert) |-> (r_res.mode != MODE_ASLEEP), "tone alert while asleep")
    // tone run is cleared on reaching its limit, so it never holds the limit
    `SLMC_ASSERT(a_tone_run_below_limit, 1'b1 |-> (r_state.tone_run < TONE_RUN_LIMIT), "tone run reached its limit")
    // state only moves when a request passes into the result register
    `SLMC_ASSERT_NORST(a_state_moves_on_advance, (i_rst_n && $past(i_rst_n) && !$past(w_advance)) |-> $stable(r_state), "state changed without a request")

endmodule

// ===== tb/slmc_checker.sv =====
// checker for the sound level light mode controller: follows register writes and
// accepted requests, predicts every result and compares it with the block output
// depends on slmc_pkg
module slmc_checker
    import slmc_pkg::*;
#(
    parameter int POWER_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_func,
    input  logic [IN_POWER_W-1:0]    i_bin_one_power,
    input  logic [IN_POWER_W-1:0]    i_bin_two_power,
    input  logic [IN_POWER_W-1:0]    i_bin_three_power,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [1:0]               i_mode,
    input  logic [DUTY_W-1:0]        i_red_duty,
    input  logic [DUTY_W-1:0]        i_green_duty,
    input  logic [DUTY_W-1:0]        i_blue_duty,
    input  logic [BLEND_INDEX_W-1:0] i_blend_index,
    input  logic                     i_tone_alert,
    input  logic                     i_sos_alert,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_tone_alerts,
    output int                       o_sos_alerts
);

    localparam logic [63:0] POWER_MASK = (64'd1 << POWER_BITS) - 64'd1;
    localparam logic [63:0] DUTY_LIMIT = 64'hB000;

    t_cfg    ctl_cfg;
    t_state  ctl_state;
    t_result expected_lights[$];
    int      fail_total;
    int      tone_total;
    int      sos_total;

    function automatic logic [DUTY_W-1:0] inverted_duty(input logic [63:0] p);
        logic [63:0] s;
        s = p >> 2;
        if (s > DUTY_LIMIT) s = DUTY_LIMIT;
        return ~s[DUTY_W-1:0];
    endfunction

    // advances the controller state by one request and returns its result
    function automatic t_result light_response(input logic is_tick,
                                               input logic [IN_POWER_W-1:0] p1,
                                               input logic [IN_POWER_W-1:0] p2,
                                               input logic [IN_POWER_W-1:0] p3);
        t_result     r;
        logic [63:0] b1, b2, b3, thr, quarter;
        r = '0;
        if (is_tick) begin
            if (ctl_state.loud_count == '0) begin
                ctl_state.quiet_ticks = ctl_state.quiet_ticks + 16'd1;
            end else begin
                ctl_state.quiet_ticks = '0;
                ctl_state.loud_count  = '0;
            end
            if (ctl_state.quiet_ticks > ctl_cfg.sleep_ticks) ctl_state.asleep = 1'b1;
            ctl_state.dance_ticks   = ctl_state.dance_ticks + 16'd1;
            ctl_state.blend_pointer = ctl_state.blend_pointer + 16'd1;
            if (ctl_state.blend_pointer >= ctl_cfg.blend_table_length)
                ctl_state.blend_pointer = '0;
            if (ctl_state.asleep) r.mode = MODE_ASLEEP;
            else if (ctl_state.hold_timer != '0) r.mode = MODE_DANCE;
            else r.mode = MODE_BLEND;
        end else begin
            b1  = 64'(p1) & POWER_MASK;
            b2  = 64'(p2) & POWER_MASK;
            b3  = 64'(p3) & POWER_MASK;
            thr = 64'(ctl_cfg.sleep_threshold);
            if (b1 > thr || b2 > thr || b3 > thr) begin
                if (ctl_state.loud_count != 8'hFF)
                    ctl_state.loud_count = ctl_state.loud_count + 8'd1;
                ctl_state.asleep = 1'b0;
            end
            r.mode = MODE_ASLEEP;
            if (!ctl_state.asleep) begin
                thr     = 64'(ctl_cfg.dance_threshold);
                quarter = thr >> 2;
                // full-width shift, so a large bin never wraps into a small one
                if (b1 > (b2 << 4) && b1 > (b3 << 4)) begin
                    ctl_state.tone_run = ctl_state.tone_run + 6'd1;
                    if (ctl_state.tone_run == TONE_RUN_LIMIT) begin
                        r.tone_alert       = 1'b1;
                        ctl_state.tone_run = '0;
                    end
                end else begin
                    ctl_state.tone_run = '0;
                end
                if ((b1 > thr && b2 > thr && b3 > thr) || ctl_state.hold_timer != '0) begin
                    if (ctl_state.hold_timer != '0)
                        ctl_state.hold_timer = ctl_state.hold_timer - 16'd1;
                    else
                        ctl_state.hold_timer = ctl_cfg.dance_hold_frames;
                    if (b1 > quarter || b2 > quarter || b3 > quarter)
                        ctl_state.hold_timer = ctl_cfg.dance_hold_frames;
                    r.red_duty   = inverted_duty(b1);
                    r.green_duty = inverted_duty(b2);
                    r.blue_duty  = inverted_duty(b3);
                    if (ctl_state.dance_ticks >= ctl_cfg.sos_ticks) begin
                        r.sos_alert           = 1'b1;
                        ctl_state.dance_ticks = '0;
                    end
                    r.mode = MODE_DANCE;
                end else begin
                    ctl_state.hold_timer  = '0;
                    ctl_state.dance_ticks = '0;
                    r.mode                = MODE_BLEND;
                end
            end
            if (ctl_state.asleep) begin
                ctl_state.quiet_ticks = '0;
                ctl_state.loud_count  = '0;
            end
        end
        r.blend_index = ctl_state.blend_pointer[15:2];
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        int      errs;
        if (!i_rst_n) begin
            ctl_cfg   = CFG_RESET;
            ctl_state = '0;
            expected_lights.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLEEP_THRESHOLD:    ctl_cfg.sleep_threshold    = i_cfg_data;
                    CFG_DANCE_THRESHOLD:    ctl_cfg.dance_threshold    = i_cfg_data;
                    CFG_DANCE_HOLD_FRAMES:  ctl_cfg.dance_hold_frames  = i_cfg_data[15:0];
                    CFG_SOS_TICKS:          ctl_cfg.sos_ticks          = i_cfg_data[15:0];
                    CFG_SLEEP_TICKS:        ctl_cfg.sleep_ticks        = i_cfg_data[15:0];
                    CFG_BLEND_TABLE_LENGTH: ctl_cfg.blend_table_length = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_lights.size() == 0) begin
                    $display("%0t: result with none expected, mode %0h", $time, i_mode);
                    fail_total++;
                end else begin
                    want = expected_lights.pop_front();
                    errs = field_differs("mode", 32'(want.mode), 32'(i_mode))
                         + field_differs("red_duty", 32'(want.red_duty), 32'(i_red_duty))
                         + field_differs("green_duty", 32'(want.green_duty),
                                         32'(i_green_duty))
                         + field_differs("blue_duty", 32'(want.blue_duty), 32'(i_blue_duty))
                         + field_differs("blend_index", 32'(want.blend_index),
                                         32'(i_blend_index))
                         + field_differs("tone_alert", 32'(want.tone_alert),
                                         32'(i_tone_alert))
                         + field_differs("sos_alert", 32'(want.sos_alert), 32'(i_sos_alert));
                    fail_total += errs;
                end
                if (i_tone_alert === 1'b1) tone_total++;
                if (i_sos_alert === 1'b1) sos_total++;
            end
            if (i_in_valid && i_in_ready)
                expected_lights.push_back(light_response(i_func, i_bin_one_power,
                                                         i_bin_two_power, i_bin_three_power));
        end
        o_pending     <= expected_lights.size();
        o_fail_count  <= fail_total;
        o_tone_alerts <= tone_total;
        o_sos_alerts  <= sos_total;
    end

endmodule

// ===== tb/testbench.sv =====
// top of the testbench for sound_level_light_mode_controller_unit: clock, reset,
// register settings and request stimulus, result stalls, watchdog and verdict
// depends on slmc_pkg, the block and slmc_checker
module testbench;
    import slmc_pkg::*;

    localparam int POWER_BITS = 32;
    localparam int IDLE_LIMIT = 500;
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

    typedef struct packed {
        logic                  func;
        logic [IN_POWER_W-1:0] one;
        logic [IN_POWER_W-1:0] two;
        logic [IN_POWER_W-1:0] three;
    } t_request;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     i_func = 1'b0;
    logic [IN_POWER_W-1:0]    i_bin_one_power = '0;
    logic [IN_POWER_W-1:0]    i_bin_two_power = '0;
    logic [IN_POWER_W-1:0]    i_bin_three_power = '0;
    logic                     i_out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [1:0]               o_mode;
    logic [DUTY_W-1:0]        o_red_duty;
    logic [DUTY_W-1:0]        o_green_duty;
    logic [DUTY_W-1:0]        o_blue_duty;
    logic [BLEND_INDEX_W-1:0] o_blend_index;
    logic                     o_tone_alert;
    logic                     o_sos_alert;

    int       fail_count;
    int       pending;
    int       tone_alerts;
    int       sos_alerts;
    int       idle_cycles = 0;
    int       sent = 0;
    int       settings_loaded = 0;
    bit       steady = 1'b0;
    t_cfg     cur;
    t_request plan[$];

    sound_level_light_mode_controller_unit #(.POWER_BITS(POWER_BITS)) i_dut (.*);

    slmc_checker #(.POWER_BITS(POWER_BITS)) lamp_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_bin_one_power  (i_bin_one_power),
        .i_bin_two_power  (i_bin_two_power),
        .i_bin_three_power(i_bin_three_power),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_mode           (o_mode),
        .i_red_duty       (o_red_duty),
        .i_green_duty     (o_green_duty),
        .i_blue_duty      (o_blue_duty),
        .i_blend_index    (o_blend_index),
        .i_tone_alert     (o_tone_alert),
        .i_sos_alert      (o_sos_alert),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_tone_alerts    (tone_alerts),
        .o_sos_alerts     (sos_alerts)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time, idle_cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: random stall before each result, with stretches of none
    initial begin : result_sink
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic void add_frame(input logic [31:0] b1, input logic [31:0] b2,
                                      input logic [31:0] b3);
        plan.push_back('{func: FUNC_FRAME, one: b1, two: b2, three: b3});
    endfunction

    function automatic void add_tick();
        plan.push_back('{func: FUNC_TICK, one: $urandom, two: $urandom, three: $urandom});
    endfunction

    function automatic logic [31:0] around(input logic [31:0] v);
        logic [31:0] r;
        case ($urandom_range(0, 2))
            0:       r = (v == '0) ? v : v - 32'd1;
            1:       r = v;
            default: r = (v == '1) ? v : v + 32'd1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] landmark();
        logic [31:0] r;
        case ($urandom_range(0, 4))
            0:       r = around(cur.sleep_threshold);
            1:       r = around(cur.dance_threshold);
            2:       r = around(cur.dance_threshold >> 2);
            3:       r = '0;
            default: r = '1;
        endcase
        return r;
    endfunction

    // mostly well-formed runs (tone runs, dance bursts, quiet tick runs) plus noise
    function automatic void add_mixture(input int unsigned count);
        int unsigned goal, len, k;
        logic [31:0] b1, b2, b3, lo;
        goal = plan.size() + count;
        while (plan.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = (cur.sleep_ticks < 12) ? $urandom_range(1, cur.sleep_ticks + 3)
                                                 : $urandom_range(1, 4);
                    repeat (len) add_tick();
                end
                3: begin
                    len = $urandom_range(38, 44);
                    for (k = 0; k < len; k++) begin
                        b1 = $urandom_range(32'hFFFF_FFFF, 32'h10);
                        b2 = $urandom_range((b1 - 32'd1) >> 4, 0);
                        b3 = $urandom_range((b1 - 32'd1) >> 4, 0);
                        // now and then a broken run
                        if ($urandom_range(0, 60) == 0) b2 = b1;
                        add_frame(b1, b2, b3);
                    end
                end
                4, 5: begin
                    len = $urandom_range(1, 6);
                    lo  = (cur.dance_threshold == '1) ? cur.dance_threshold
                                                      : cur.dance_threshold + 32'd1;
                    for (k = 0; k < len; k++) begin
                        repeat ($urandom_range(0, 2)) add_tick();
                        if ($urandom_range(0, 3) == 0)
                            add_frame(around(cur.dance_threshold >> 2), 32'd0, 32'd0);
                        else
                            add_frame($urandom_range(32'hFFFF_FFFF, lo),
                                      $urandom_range(32'hFFFF_FFFF, lo),
                                      $urandom_range(32'hFFFF_FFFF, lo));
                    end
                end
                6: begin
                    repeat ($urandom_range(1, 3))
                        add_frame($urandom_range(cur.sleep_threshold, 0),
                                  $urandom_range(cur.sleep_threshold, 0),
                                  $urandom_range(cur.sleep_threshold, 0));
                end
                7: add_frame($urandom >> $urandom_range(0, 31), $urandom,
                             $urandom >> $urandom_range(0, 31));
                8: add_frame(landmark(), landmark(), landmark());
                default: begin
                    if ($urandom_range(0, 1) == 0) add_tick();
                    else add_frame($urandom, $urandom, $urandom);
                end
            endcase
        end
    endfunction

    function automatic t_cfg modest_settings();
        t_cfg c;
        c.sleep_threshold    = $urandom_range(0, 2000);
        c.dance_threshold    = $urandom_range(2000, 1 << 20);
        c.dance_hold_frames  = 16'($urandom_range(0, 6));
        c.sos_ticks          = 16'($urandom_range(0, 30));
        c.sleep_ticks        = 16'($urandom_range(0, 8));
        c.blend_table_length = 16'($urandom_range(1, 64));
        return c;
    endfunction

    task automatic send_request(input t_request rq);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= rq.func;
        i_bin_one_power   <= rq.one;
        i_bin_two_power   <= rq.two;
        i_bin_three_power <= rq.three;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_plan(input int pause_at);
        for (int k = 0; k < plan.size(); k++) begin
            if (k % 32 == 0) steady = ($urandom_range(0, 3) == 0);
            if (k == pause_at) drain();
            send_request(plan[k]);
            sent++;
        end
        plan.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // only with the block empty; the narrow registers get junk in the upper bits
    task automatic load_settings(input t_cfg c);
        drain();
        repeat (3) @(posedge i_clk);
        write_reg(CFG_SLEEP_THRESHOLD, c.sleep_threshold);
        write_reg(CFG_DANCE_THRESHOLD, c.dance_threshold);
        write_reg(CFG_DANCE_HOLD_FRAMES, {16'($urandom), c.dance_hold_frames});
        write_reg(CFG_SOS_TICKS, {16'($urandom), c.sos_ticks});
        write_reg(CFG_SLEEP_TICKS, {16'($urandom), c.sleep_ticks});
        write_reg(CFG_BLEND_TABLE_LENGTH, {16'($urandom), c.blend_table_length});
        write_reg(UNUSED_REG_IDX, $urandom);
        i_cfg_we <= 1'b0;
        cur = c;
        settings_loaded++;
    endtask

    initial begin : stimulus
        t_cfg c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur = CFG_RESET;

        // register defaults: duty clamp, hold reload, tone shift edges, thresholds
        add_tick();
        add_frame(32'd0, 32'd0, 32'd0);
        add_frame('1, '1, '1);
        add_frame(32'd0, 32'd0, 32'd0);
        add_frame(32'd25001, 32'd0, 32'd0);
        add_frame(32'd25000, 32'd0, 32'd0);
        add_frame(32'h2C000, 32'h2BFFC, 32'h2BFFF);
        add_tick();
        add_frame(32'h10000, 32'h0FFF, 32'd0);
        add_frame(32'h10000, 32'h1000, 32'd0);
        add_frame('1, 32'h1000_0000, 32'h0FFF_FFFF);
        add_frame(32'd100001, 32'd100001, 32'd100001);
        add_frame(32'd100000, 32'd100001, 32'd100001);
        add_frame(32'd1000, 32'd1000, 32'd1000);
        add_frame(32'd1001, 32'd0, 32'd0);
        add_frame(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
        add_frame(32'd4, 32'd8, 32'd3);
        add_tick();
        run_plan(-1);

        load_settings(modest_settings());
        add_mixture(40);
        run_plan(-1);

        // all registers at zero but the blend table length at one; loud counter must saturate, not wrap
        c = '{sleep_threshold: '0, dance_threshold: '0, dance_hold_frames: '0,
              sos_ticks: '0, sleep_ticks: '0, blend_table_length: 16'd1};
        load_settings(c);
        add_tick();
        repeat (256) add_frame($urandom_range(32'hFFFF_FFFF, 1), $urandom, $urandom);
        add_tick();
        add_tick();
        add_frame(32'd0, 32'd0, 32'd0);
        add_mixture(20);
        run_plan(-1);

        c = '{sleep_threshold: '1, dance_threshold: '1, dance_hold_frames: '1,
              sos_ticks: '1, sleep_ticks: '1, blend_table_length: '1};
        load_settings(c);
        add_mixture(30);
        run_plan(-1);

        c.sleep_threshold    = $urandom >> $urandom_range(0, 31);
        c.dance_threshold    = $urandom >> $urandom_range(0, 31);
        c.dance_hold_frames  = 16'($urandom_range(0, 65535));
        c.sos_ticks          = 16'($urandom_range(0, 65535));
        c.sleep_ticks        = 16'($urandom_range(0, 65535));
        c.blend_table_length = 16'($urandom_range(1, 65535));
        load_settings(c);
        add_mixture(30);
        run_plan(-1);

        load_settings(modest_settings());
        add_mixture(70);
        run_plan(45);

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d requests under %0d register settings", sent, settings_loaded + 1);
        $display("alerts seen: %0d tone, %0d sos; %0d mismatches", tone_alerts, sos_alerts,
                 fail_count);
        if (fail_count == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule
